// ===== rtl/drm_pkg.sv =====
// Shared types and constants of the dirty rectangle merger.
`default_nettype none

package drm_pkg;

  localparam int XY_W = 11;
  localparam int WH_W = 12;
  localparam int END_W = 13;

  localparam int MAX_RECTS_DEFAULT = 16;

  localparam logic KIND_NOTIFY = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;

  typedef struct packed {
    logic [XY_W-1:0] x;
    logic [XY_W-1:0] y;
    logic [WH_W-1:0] w;
    logic [WH_W-1:0] h;
  } box_t;

  localparam int BOX_W = $bits(box_t);

endpackage

`default_nettype wire

// ===== rtl/drm_if.sv =====
// Handshake channels for notify/flush items and emitted rectangles.
`default_nettype none

interface drm_in_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [drm_pkg::XY_W-1:0]  rect_x;
  logic [drm_pkg::XY_W-1:0]  rect_y;
  logic [drm_pkg::WH_W-1:0]  rect_w;
  logic [drm_pkg::WH_W-1:0]  rect_h;

  modport source (output valid, kind, rect_x, rect_y, rect_w, rect_h, input ready);
  modport sink   (input valid, kind, rect_x, rect_y, rect_w, rect_h, output ready);
endinterface

interface drm_out_if;
  logic                      valid;
  logic                      ready;
  logic [drm_pkg::XY_W-1:0]  out_x;
  logic [drm_pkg::XY_W-1:0]  out_y;
  logic [drm_pkg::WH_W-1:0]  out_w;
  logic [drm_pkg::WH_W-1:0]  out_h;
  logic                      last;

  modport source (output valid, out_x, out_y, out_w, out_h, last, input ready);
  modport sink   (input valid, out_x, out_y, out_w, out_h, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/drm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module drm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]  wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/drm_box_unit.sv =====
// Overlap test and bounding-box join of a stored rectangle with a new one.
`default_nettype none

module drm_box_unit (
  input  wire drm_pkg::box_t entry_i,
  input  wire drm_pkg::box_t new_i,
  output logic               touch_o,
  output drm_pkg::box_t      join_o
);

  localparam int EW = drm_pkg::END_W;

  logic [EW-1:0] ax, ay, bx, by;
  logic [EW-1:0] axe, aye, bxe, bye;
  logic [EW-1:0] x0, y0, xe, ye, sw, sh;

  always_comb begin
    ax  = EW'(entry_i.x);
    ay  = EW'(entry_i.y);
    bx  = EW'(new_i.x);
    by  = EW'(new_i.y);
    axe = ax + EW'(entry_i.w);
    aye = ay + EW'(entry_i.h);
    bxe = bx + EW'(new_i.w);
    bye = by + EW'(new_i.h);

    // Open intervals must intersect on both axes.
    touch_o = !((axe <= bx) || (bxe <= ax) || (aye <= by) || (bye <= ay));

    x0 = (ax < bx) ? ax : bx;
    y0 = (ay < by) ? ay : by;
    xe = (axe > bxe) ? axe : bxe;
    ye = (aye > bye) ? aye : bye;
    sw = xe - x0;
    sh = ye - y0;

    join_o.x = x0[drm_pkg::XY_W-1:0];
    join_o.y = y0[drm_pkg::XY_W-1:0];
    join_o.w = sw[EW-1] ? '1 : sw[drm_pkg::WH_W-1:0];
    join_o.h = sh[EW-1] ? '1 : sh[drm_pkg::WH_W-1:0];
  end

endmodule

`default_nettype wire

// ===== rtl/dirty_rectangle_merger.sv =====
// Top level of the dirty rectangle merger: sequencer, table RAM and output register.
`default_nettype none

// The block keeps a table of up to MAX_RECTS dirty rectangles in a RAM. A notify item
// is compared against the stored entries one per cycle through a single shared
// overlap/join unit; the first entry whose open intervals intersect the new
// rectangle on both axes is replaced by the bounding box of the two (sizes saturate
// at 4095). If none overlaps, the rectangle is appended, or, when the table is full,
// joined into the last entry. A notify into an empty table is written directly and
// leaves the block ready; otherwise the block stays busy until it has examined the
// entries up to the first overlap (at most the fill count), reading them through the
// RAM read port. A flush item emits every stored rectangle in table order, one per
// cycle while the receiver keeps up, with last set on the final one, then empties
// the table; it holds the block until the final one is in the output register. An
// empty table emits nothing. Results sit in an output register, so a new
// item can be taken while the final rectangle of a flush still waits to be
// collected. The table needs no clearing after reset: only entries below the fill
// count are ever read.

module dirty_rectangle_merger #(
  parameter int MAX_RECTS = drm_pkg::MAX_RECTS_DEFAULT
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  drm_in_if.sink     in_ch_i,
  drm_out_if.source  out_ch_o
);

  localparam int IDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int CNT_W = $clog2(MAX_RECTS + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MERGE = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] count_q, count_d;
  drm_pkg::box_t    nb_q, nb_d;

  drm_pkg::box_t    out_box_q, out_box_d;
  logic             out_last_q, out_last_d;
  logic             out_valid_q, out_valid_d;

  logic             wr_en, rd_en;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  drm_pkg::box_t    wr_data, rd_data;
  logic [drm_pkg::BOX_W-1:0] rd_word;

  logic             touch;
  drm_pkg::box_t    joined;
  drm_pkg::box_t    in_box;
  logic             accept, is_last;

  drm_ram #(
    .WIDTH (drm_pkg::BOX_W),
    .DEPTH (MAX_RECTS)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_word)
  );

  assign rd_data = rd_word;

  drm_box_unit u_box (
    .entry_i (rd_data),
    .new_i   (nb_q),
    .touch_o (touch),
    .join_o  (joined)
  );

  assign in_box.x = in_ch_i.rect_x;
  assign in_box.y = in_ch_i.rect_y;
  assign in_box.w = in_ch_i.rect_w;
  assign in_box.h = in_ch_i.rect_h;

  assign in_ch_i.ready = (state_q == ST_IDLE);
  assign accept        = in_ch_i.valid && in_ch_i.ready;

  // The entry in the read register is the final valid one of the table.
  assign is_last = (CNT_W'(idx_q) == (count_q - CNT_W'(1)));

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    count_d     = count_q;
    nb_d        = nb_q;
    out_box_d   = out_box_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q;
    wr_en       = 1'b0;
    wr_addr     = idx_q;
    wr_data     = joined;
    rd_en       = 1'b0;
    rd_addr     = '0;

    if (out_valid_q && out_ch_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_ch_i.kind == drm_pkg::KIND_NOTIFY) begin
            nb_d = in_box;
            if (count_q == '0) begin
              // Empty table: the rectangle goes straight into the first entry.
              wr_en   = 1'b1;
              wr_addr = '0;
              wr_data = in_box;
              count_d = CNT_W'(1);
            end else begin
              rd_en   = 1'b1;
              idx_d   = '0;
              state_d = ST_MERGE;
            end
          end else if (count_q != '0) begin
            rd_en   = 1'b1;
            idx_d   = '0;
            state_d = ST_FLUSH;
          end
        end
      end

      ST_MERGE: begin
        if (touch) begin
          wr_en   = 1'b1;
          state_d = ST_IDLE;
        end else if (is_last) begin
          wr_en   = 1'b1;
          state_d = ST_IDLE;
          if (count_q != CNT_W'(MAX_RECTS)) begin
            wr_addr = count_q[IDX_W-1:0];
            wr_data = nb_q;
            count_d = count_q + CNT_W'(1);
          end
          // A full table joins the rectangle into its last entry, which is the
          // one just compared.
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          rd_en   = 1'b1;
          rd_addr = idx_q + IDX_W'(1);
        end
      end

      ST_FLUSH: begin
        if (!out_valid_q || out_ch_o.ready) begin
          out_box_d   = rd_data;
          out_last_d  = is_last;
          out_valid_d = 1'b1;
          if (is_last) begin
            count_d = '0;
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            rd_en   = 1'b1;
            rd_addr = idx_q + IDX_W'(1);
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nb_q       <= nb_d;
    out_box_q  <= out_box_d;
    out_last_q <= out_last_d;
  end

  assign out_ch_o.valid = out_valid_q;
  assign out_ch_o.out_x = out_box_q.x;
  assign out_ch_o.out_y = out_box_q.y;
  assign out_ch_o.out_w = out_box_q.w;
  assign out_ch_o.out_h = out_box_q.h;
  assign out_ch_o.last  = out_last_q;

endmodule

`default_nettype wire
